### sv/dvc_pkg.sv
// Shared constants, types and controller/datapath signal groups for the distinct value counter.
package dvc_pkg;

    localparam int MAX_DISTINCT = 256;
    localparam int VALUE_W      = 32;
    localparam int ADDR_W       = (MAX_DISTINCT > 1) ? $clog2(MAX_DISTINCT) : 1;
    localparam int CNT_W        = $clog2(MAX_DISTINCT + 1);
    localparam int OUT_CNT_W    = 9;

    typedef logic [VALUE_W-1:0]   t_value;
    typedef logic [ADDR_W-1:0]    t_addr;
    typedef logic [CNT_W-1:0]     t_cnt;
    typedef logic [OUT_CNT_W-1:0] t_out_cnt;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // capture the incoming word and start a new search
        logic rd;      // read the store at the search index and advance it
        logic cmp;     // read data from the previous cycle is valid for compare
        logic commit;  // update store, count and flags, load the result register
    } t_dvc_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic more;    // entries remain below the fill count
        logic eq;      // registered read data equals the captured value
    } t_dvc_sts;

endpackage

### sv/dvc_if.sv
// Stream interfaces for the input and result channels.
interface dvc_in_if;
    logic              valid;
    logic              ready;
    dvc_pkg::t_value   value;
    logic              last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

interface dvc_out_if;
    logic              valid;
    logic              ready;
    dvc_pkg::t_out_cnt distinct_count;
    logic              is_new;
    logic              overflow;
    logic              set_end;

    modport source (output valid, output distinct_count, output is_new,
                    output overflow, output set_end, input ready);
    modport sink   (input valid, input distinct_count, input is_new,
                    input overflow, input set_end, output ready);
endinterface

### sv/dvc_ctrl.sv
// Controller state machine that sequences the serial search and the result handoff.
module dvc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_out_ready,
    input  dvc_pkg::t_dvc_sts i_sts,
    output logic              o_in_ready,
    output logic              o_out_valid,
    output dvc_pkg::t_dvc_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_pend, n_pend;
    logic   r_out_valid, n_out_valid;
    logic   out_free;
    logic   hit_now;

    assign out_free    = !r_out_valid || i_out_ready;
    assign hit_now     = r_pend && i_sts.eq;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_pend      = r_pend;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_pend     = 1'b0;
                    n_state    = S_SEARCH;
                end
            end
            S_SEARCH: begin
                // The compare of the last read overlaps the next read.
                o_cmd.cmp = r_pend;
                o_cmd.rd  = i_sts.more && !hit_now;
                n_pend    = i_sts.more && !hit_now;
                if (hit_now || !i_sts.more) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.commit = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

### sv/dvc_dp.sv
// Datapath: value store, search index, fill count, overflow flag and result register.
module dvc_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  dvc_pkg::t_dvc_cmd   i_cmd,
    input  dvc_pkg::t_value     i_value,
    input  logic                i_last,
    output dvc_pkg::t_dvc_sts   o_sts,
    output dvc_pkg::t_out_cnt   o_distinct_count,
    output logic                o_is_new,
    output logic                o_overflow,
    output logic                o_set_end
);

    dvc_pkg::t_value mem [dvc_pkg::MAX_DISTINCT];

    dvc_pkg::t_value   r_val;
    logic              r_last;
    dvc_pkg::t_cnt     r_idx;
    dvc_pkg::t_value   r_rdata;
    logic              r_found;
    dvc_pkg::t_cnt     r_used, n_used;
    logic              r_ovf, n_ovf;
    dvc_pkg::t_out_cnt r_out_cnt;
    logic              r_out_new;
    logic              r_out_ovf;
    logic              r_out_end;
    logic              fresh;
    logic              full;

    assign o_sts.more = (r_idx < r_used);
    assign o_sts.eq   = (r_rdata == r_val);

    assign fresh  = !r_found;
    assign full   = (r_used == dvc_pkg::t_cnt'(dvc_pkg::MAX_DISTINCT));
    assign n_used = (fresh && !full) ? (r_used + dvc_pkg::t_cnt'(1)) : r_used;
    assign n_ovf  = r_ovf || (fresh && full);

    // Store: one read port for the search, one write port for a new value.
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rdata <= mem[r_idx[dvc_pkg::ADDR_W-1:0]];
        end
        if (i_cmd.commit && fresh && !full) begin
            mem[r_used[dvc_pkg::ADDR_W-1:0]] <= r_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_val  <= i_value;
            r_last <= i_last;
        end
        if (i_cmd.commit) begin
            r_out_cnt <= dvc_pkg::t_out_cnt'(n_used);
            r_out_new <= fresh;
            r_out_ovf <= n_ovf;
            r_out_end <= r_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_found <= 1'b0;
            r_used  <= '0;
            r_ovf   <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_idx   <= '0;
                r_found <= 1'b0;
            end else begin
                if (i_cmd.rd) begin
                    r_idx <= r_idx + dvc_pkg::t_cnt'(1);
                end
                if (i_cmd.cmp && o_sts.eq) begin
                    r_found <= 1'b1;
                end
            end
            if (i_cmd.commit) begin
                // The last word of a set leaves the count and flag clear.
                r_used <= r_last ? '0 : n_used;
                r_ovf  <= r_last ? 1'b0 : n_ovf;
            end
        end
    end

    assign o_distinct_count = r_out_cnt;
    assign o_is_new         = r_out_new;
    assign o_overflow       = r_out_ovf;
    assign o_set_end        = r_out_end;

endmodule

### sv/distinct_value_counter.sv
// Top level of the distinct value counter: controller, datapath and channel hookup.
//
//   channel   dir   payload                                       handshake
//   i_in      in    value[31:0], last                             valid/ready
//   o_out     out   distinct_count[8:0], is_new, overflow, set_end valid/ready
//
// An input word is compared against the N distinct values already stored for
// the set (at most 256): the store has one read port and is scanned one entry
// per cycle, and a match ends the scan early.
// A finished result sits in an output register, so a stalled output holds at
// most one result while the next word is already being searched.
// Reset is synchronous and active low; it clears the count and overflow flag.
// The store itself is not cleared, since only entries below the count are read.
module distinct_value_counter (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dvc_in_if.sink    i_in,
    dvc_out_if.source o_out
);

    dvc_pkg::t_dvc_cmd cmd;
    dvc_pkg::t_dvc_sts sts;

    dvc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (sts),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (cmd)
    );

    dvc_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_value          (i_in.value),
        .i_last           (i_in.last),
        .o_sts            (sts),
        .o_distinct_count (o_out.distinct_count),
        .o_is_new         (o_out.is_new),
        .o_overflow       (o_out.overflow),
        .o_set_end        (o_out.set_end)
    );

    // Every result counts at least the word that produced it.
    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> o_out.distinct_count != '0)
        else $error("result word with zero distinct count");

    // Overflow can only be reported once the store is full.
    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.overflow |->
            o_out.distinct_count == dvc_pkg::t_out_cnt'(dvc_pkg::MAX_DISTINCT))
        else $error("overflow reported with store not full");

    // Once a word is accepted, the input stays closed while its search runs.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> !i_in.ready)
        else $error("second word accepted while a search is running");

endmodule
